// ===== src/swm_pkg.sv =====
// Package for the sliding window median filter: sizes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;
    localparam int WindowMax   = 256;
    localparam int SampleWidth = 16;
    localparam int AddrWidth   = $clog2(WindowMax);
    localparam int CountWidth  = AddrWidth + 1;
    localparam int MedWidth    = SampleWidth + 1;
    localparam logic [CountWidth-1:0] LenReset = CountWidth'(9);

    typedef logic signed [SampleWidth-1:0] t_sample;
    typedef logic [AddrWidth-1:0]          t_addr;
    typedef logic [CountWidth-1:0]         t_count;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DL_RD,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_RM_LAST_RD,
        ST_RM_LAST_WAIT,
        ST_SD_RD,
        ST_SD_L,
        ST_SD_R,
        ST_SD_CMP,
        ST_SU_RD,
        ST_SU_CMP,
        ST_RB_CHECK,
        ST_POP_LAST_RD,
        ST_POP_LAST_WAIT,
        ST_INS_TOP_RD,
        ST_INS_TOP_WAIT,
        ST_PUSH,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_REMOVE,
        PH_REBAL1,
        PH_INSERT,
        PH_REBAL2
    } t_phase;

    // Port request to one heap memory.
    typedef struct packed {
        logic    we;
        t_addr   addr;
        t_sample wdata;
    } t_mem_req;
endpackage
`default_nettype wire

// ===== src/swm_ram.sv =====
// Single port synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module swm_ram #(
    parameter int Depth = 256,
    parameter int Width = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== src/sliding_window_median_filter_top.sv =====
// Sliding window median filter top: heap sequencer around three RAMs.
// Depends on swm_pkg and swm_ram.
//
// channel  dir  handshake             payload
// s_axis   in   tvalid/tready         tdata[15:0] sample
// m_axis   out  tvalid/tready         tdata[16:0] median_times_two, tuser window_full
// cfg      in   i_cfg_we              i_cfg_wdata[8:0] window_len
//
// One transaction at a time; the time an item takes is set by the linear
// search through the heap RAMs and the heap sift loops over their single
// port. Reset empties the window and sets the length to 9. Input is held
// off until the result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_median_filter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,  // [16:0] median_times_two, zero fill
    output logic             m_axis_tuser,  // [0] window_full
    input  wire logic        i_cfg_we,
    input  wire logic [8:0]  i_cfg_wdata    // [8:0] window_len
);
    import swm_pkg::*;

    t_state  r_state, n_state;
    t_phase  r_phase, n_phase;
    t_count  r_len, r_lcnt, n_lcnt, r_hcnt, n_hcnt, r_fill, n_fill;
    t_addr   r_wp, n_wp;
    t_sample r_s, n_s, r_old, n_old, r_v, n_v, r_cv, n_cv, r_lv, n_lv, r_ltop, n_ltop;
    t_addr   r_i, n_i, r_best, n_best;
    logic    r_hs, n_hs;          // heap under work: 1 = high (min) heap
    logic    r_sdonly, n_sdonly;  // sift down without follow up sift up
    logic    r_ovalid;
    logic signed [MedWidth-1:0] r_med;
    logic    r_full;
    t_count  eff_len;

    t_mem_req lreq, hreq;
    logic     dl_we;
    t_addr    dl_addr;
    t_sample  l_rd, h_rd, dl_rd, cur_rd;

    swm_ram #(.Depth(WindowMax), .Width(SampleWidth)) u_low (
        .i_clk(i_clk), .i_we(lreq.we), .i_addr(lreq.addr), .i_wdata(lreq.wdata),
        .o_rdata(l_rd));
    swm_ram #(.Depth(WindowMax), .Width(SampleWidth)) u_high (
        .i_clk(i_clk), .i_we(hreq.we), .i_addr(hreq.addr), .i_wdata(hreq.wdata),
        .o_rdata(h_rd));
    swm_ram #(.Depth(WindowMax), .Width(SampleWidth)) u_dl (
        .i_clk(i_clk), .i_we(dl_we), .i_addr(dl_addr), .i_wdata(r_s),
        .o_rdata(dl_rd));

    always_comb begin
        if (r_len == '0) begin
            eff_len = t_count'(1);
        end else if (r_len > t_count'(WindowMax)) begin
            eff_len = t_count'(WindowMax);
        end else begin
            eff_len = r_len;
        end
    end

    assign cur_rd = r_hs ? h_rd : l_rd;

    // a before b in the heap under work
    function automatic logic prec(input logic hs, input t_sample a, input t_sample b);
        prec = hs ? (a < b) : (a > b);
    endfunction

    t_count  cnt;
    t_addr   lc, rc, par, last;
    logic    mem_we;
    t_addr   mem_addr;
    t_sample mem_wd;

    assign cnt  = r_hs ? r_hcnt : r_lcnt;
    assign lc   = t_addr'({r_i, 1'b1});
    assign rc   = t_addr'({r_i, 1'b0} + 2);
    assign par  = t_addr'((r_i - 1) >> 1);
    assign last = t_addr'(cnt - 1);

    // next state
    always_comb begin
        logic [CountWidth:0] l2;
        n_state = r_state; n_phase = r_phase;
        n_lcnt = r_lcnt; n_hcnt = r_hcnt; n_fill = r_fill; n_wp = r_wp;
        n_s = r_s; n_old = r_old; n_v = r_v; n_cv = r_cv; n_lv = r_lv; n_ltop = r_ltop;
        n_i = r_i; n_best = r_best; n_hs = r_hs; n_sdonly = r_sdonly;
        l2 = {1'b0, r_i, 1'b1};
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_s = s_axis_tdata;
                    if (t_count'(r_wp) >= eff_len) n_wp = '0;
                    if (r_fill >= eff_len) begin
                        n_state = ST_DL_RD;
                    end else begin
                        n_fill = r_fill + 1'b1;
                        n_phase = PH_INSERT; n_state = ST_RB_CHECK;
                    end
                end
            end
            ST_DL_RD: begin
                n_state = ST_SRCH_RD; n_hs = 1'b0; n_i = '0; n_phase = PH_REMOVE;
            end
            ST_SRCH_RD: begin
                if (r_i == '0 && r_hs == 1'b0) n_old = dl_rd;
                if (t_count'(r_i) >= cnt) begin
                    if (r_hs) begin
                        n_phase = PH_REBAL1; n_state = ST_RB_CHECK;
                    end else begin
                        n_hs = 1'b1; n_i = '0;
                    end
                end else begin
                    n_state = ST_SRCH_CHK;
                end
            end
            ST_SRCH_CHK: begin
                if (cur_rd == r_old) begin
                    if (r_hs) n_hcnt = r_hcnt - 1'b1; else n_lcnt = r_lcnt - 1'b1;
                    n_state = ST_RM_LAST_RD;
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_SRCH_RD;
                end
            end
            ST_RM_LAST_RD: n_state = ST_RM_LAST_WAIT;
            ST_RM_LAST_WAIT: begin
                n_v = cur_rd;
                if (t_count'(r_i) < cnt) begin
                    n_sdonly = 1'b0; n_state = ST_SD_RD;
                end else begin
                    n_phase = PH_REBAL1; n_state = ST_RB_CHECK;
                end
            end
            // sift down: r_v belongs at slot r_i, written once its place is found
            ST_SD_RD: begin
                n_best = r_i; n_cv = r_v;
                n_state = (l2 < {1'b0, cnt}) ? ST_SD_L : ST_SD_CMP;
            end
            ST_SD_L: begin
                if (prec(r_hs, cur_rd, r_cv)) begin n_best = lc; n_cv = cur_rd; end
                n_state = (l2 + 1'b1 < {1'b0, cnt}) ? ST_SD_R : ST_SD_CMP;
            end
            ST_SD_R: begin
                if (prec(r_hs, cur_rd, r_cv)) begin n_best = rc; n_cv = cur_rd; end
                n_state = ST_SD_CMP;
            end
            ST_SD_CMP: begin
                if (r_best == r_i) begin
                    if (r_sdonly) begin
                        n_state = ST_RB_CHECK;
                    end else begin
                        n_state = ST_SU_RD;
                    end
                end else begin
                    n_i = r_best; n_state = ST_SD_RD;
                end
            end
            ST_SU_RD: begin
                if (r_i == '0) n_state = ST_RB_CHECK; else n_state = ST_SU_CMP;
            end
            ST_SU_CMP: begin
                if (prec(r_hs, r_v, cur_rd)) begin
                    n_i = par; n_state = ST_SU_RD;
                end else begin
                    n_state = ST_RB_CHECK;
                end
            end
            ST_RB_CHECK: begin
                n_sdonly = 1'b1;
                if (r_phase == PH_INSERT) begin
                    n_state = ST_INS_TOP_RD;
                end else if (r_lcnt > r_hcnt + 1) begin
                    n_hs = 1'b0; n_lcnt = r_lcnt - 1'b1; n_state = ST_POP_LAST_RD;
                end else if (r_hcnt > r_lcnt) begin
                    n_hs = 1'b1; n_hcnt = r_hcnt - 1'b1; n_state = ST_POP_LAST_RD;
                end else if (r_phase == PH_REBAL2) begin
                    n_state = ST_OUT_RD;
                end else begin
                    n_phase = PH_INSERT; n_state = ST_INS_TOP_RD;
                end
            end
            // pop: read top, read last, write last to top, sift down, push top
            ST_POP_LAST_RD: n_state = ST_POP_LAST_WAIT;
            ST_POP_LAST_WAIT: begin
                n_ltop = cur_rd; // top
                n_state = ST_SD_RD;
                n_i = '0;
            end
            ST_INS_TOP_RD: n_state = ST_INS_TOP_WAIT;
            ST_INS_TOP_WAIT: begin
                n_v = r_s;
                n_hs = !(r_lcnt == '0 || r_s <= l_rd);
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                n_i = t_addr'(cnt);
                if (r_hs) n_hcnt = r_hcnt + 1'b1; else n_lcnt = r_lcnt + 1'b1;
                n_phase = (r_phase == PH_INSERT) ? PH_REBAL2 : r_phase;
                n_state = ST_SU_RD;
            end
            ST_OUT_RD: n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                n_wp = (t_count'(r_wp) + 1 >= eff_len) ? '0 : r_wp + 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        // pop wait: the value read is the last entry, the top comes from the
        // extra register path below
        if (r_state == ST_POP_LAST_WAIT) begin
            n_v = cur_rd; n_ltop = r_lv;
        end
        if (r_state == ST_POP_LAST_RD) n_lv = cur_rd;
        // after pop sift down, push the old top on the other heap
        if (r_state == ST_SD_CMP && r_best == r_i && r_sdonly) begin
            n_hs = !r_hs; n_v = r_ltop; n_state = ST_PUSH;
        end
    end

    // memory requests
    always_comb begin
        mem_we = 1'b0; mem_addr = r_i; mem_wd = r_v; dl_we = 1'b0; dl_addr = r_wp;
        case (r_state)
            ST_SRCH_RD: mem_addr = r_i;
            ST_RM_LAST_RD: mem_addr = last + 1'b1;
            ST_RM_LAST_WAIT: begin
                mem_we = t_count'(r_i) < cnt; mem_addr = r_i; mem_wd = cur_rd;
            end
            ST_SD_L: mem_addr = rc;
            ST_SD_RD: mem_addr = lc;
            ST_SD_R: mem_addr = rc;
            ST_SD_CMP: begin
                if (r_best != r_i) begin
                    mem_we = 1'b1; mem_addr = r_i; mem_wd = r_cv;
                end else begin
                    mem_we = 1'b1; mem_addr = r_i; mem_wd = r_v;
                end
            end
            ST_SU_RD: begin
                mem_addr = par;
                if (r_i == '0) begin
                    mem_we = 1'b1; mem_addr = '0; mem_wd = r_v;
                end
            end
            ST_SU_CMP: begin
                mem_we = 1'b1; mem_addr = r_i;
                mem_wd = prec(r_hs, r_v, cur_rd) ? cur_rd : r_v;
            end
            ST_POP_LAST_RD: mem_addr = last + 1'b1;
            ST_POP_LAST_WAIT: mem_addr = '0;
            ST_RB_CHECK: mem_addr = '0;
            ST_INS_TOP_RD: mem_addr = '0;
            ST_PUSH: begin
                mem_we = 1'b1; mem_addr = t_addr'(cnt); mem_wd = r_v;
            end
            ST_OUT_RD: begin
                mem_addr = '0; dl_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        lreq = '{we: mem_we && !r_hs, addr: mem_addr, wdata: mem_wd};
        hreq = '{we: mem_we && r_hs, addr: mem_addr, wdata: mem_wd};
        if (r_state == ST_INS_TOP_RD || r_state == ST_OUT_RD) begin
            lreq.addr = '0; hreq.addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_phase <= PH_REMOVE; r_len <= LenReset;
            r_lcnt <= '0; r_hcnt <= '0; r_fill <= '0; r_wp <= '0;
            r_ovalid <= 1'b0; r_hs <= 1'b0; r_sdonly <= 1'b0;
        end else begin
            r_state <= n_state; r_phase <= n_phase; r_hs <= n_hs;
            r_sdonly <= n_sdonly;
            r_ovalid <= (n_state == ST_OUT);
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata; r_lcnt <= '0; r_hcnt <= '0;
                r_fill <= '0; r_wp <= '0;
            end else begin
                r_lcnt <= n_lcnt; r_hcnt <= n_hcnt; r_fill <= n_fill; r_wp <= n_wp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s; r_old <= n_old; r_v <= n_v; r_cv <= n_cv; r_lv <= n_lv;
        r_ltop <= n_ltop; r_i <= n_i; r_best <= n_best;
        if (r_state == ST_OUT_WAIT) begin
            r_full <= r_fill >= eff_len;
            if (r_lcnt > r_hcnt || r_hcnt == '0) begin
                r_med <= {l_rd, 1'b0};
            end else begin
                r_med <= MedWidth'(l_rd) + MedWidth'(h_rd);
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'b0, r_med};
    assign m_axis_tuser  = r_full;

`ifndef SYNTH
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_lcnt} + {1'b0, r_hcnt}) <= (CountWidth + 1)'(WindowMax))
        else $error("heap counts overflow");
`endif
endmodule
`default_nettype wire
